// ===== rtl/bqsl_pkg.sv =====
// Package for the bounded queue/stack/list unit: request and response
// structs, request and status codes, sequencer states, cell control struct.
// No dependencies.
package bqsl_pkg;

    // Request codes
    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PEEK_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_BACK  = 3'd4,
        OP_GET        = 3'd5,
        OP_CONTAINS   = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } state_t;

    // One stored element
    typedef struct packed {
        logic signed [31:0] second;
        logic signed [31:0] first;
    } elem_t;

    // Request transaction
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] element_first;
        logic signed [31:0] element_second;
        logic [7:0]         position;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_first;
        logic signed [31:0] value_second;
        logic               found;
        logic [8:0]         count;
        logic               is_full_flag;
        logic               is_empty_flag;
    } rsp_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic push;   // cell at the write index loads the push element
        logic shift;  // every cell takes its right neighbor
        logic wrap;   // cell at the wrap index takes the head instead
    } cell_ctl_t;

endpackage

// ===== rtl/bqsl_cell.sv =====
// One storage cell of the element chain: holds one element and takes its
// right neighbor on a shift, or the head element at the wrap point.
// Depends on bqsl_pkg.
module bqsl_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  bqsl_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [IDX_W-1:0]   wrap_idx,
    input  bqsl_pkg::elem_t    wr_data,
    input  bqsl_pkg::elem_t    right,
    input  bqsl_pkg::elem_t    head,
    output bqsl_pkg::elem_t    q
);
    import bqsl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    elem_t data_reg;
    elem_t data_next;

    // Load, shift toward the front, or wrap the head around to the tail
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push && (wr_idx == MY_IDX))
        begin
            data_next = wr_data;
        end
        else if (ctl.shift)
        begin
            if (ctl.wrap && (wrap_idx == MY_IDX))
                data_next = head;
            else
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== rtl/bqsl_ctrl.sv =====
// Sequencer for the unit: element count, request decode, search walk,
// registered response and the element kind register.
// Depends on bqsl_pkg.
module bqsl_ctrl #(
    parameter int CAPACITY = 256,
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bqsl_pkg::req_t    req,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  bqsl_pkg::elem_t   head,
    input  bqsl_pkg::elem_t   rd_data,
    output bqsl_pkg::cell_ctl_t ctl,
    output logic [IDX_W-1:0]  wr_idx,
    output logic [IDX_W-1:0]  wrap_idx,
    output logic [IDX_W-1:0]  rd_idx,
    output bqsl_pkg::elem_t   wr_data,
    output logic              done,
    output bqsl_pkg::rsp_t    rsp
);
    import bqsl_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic             found_reg, found_next;
    elem_t            key_reg, key_next;
    logic             kind_cfg_reg;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    logic             accept;
    logic             list_vacant;
    logic             is_full;
    logic [CNT_W-1:0] count_m1;
    logic             pos_bad;
    logic             hit;
    logic [1:0]       status;
    elem_t            value;
    logic             found_out;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg == S_SEARCH);
    assign list_vacant = (count_reg == '0);
    assign is_full     = (count_reg == CAP_CNT);
    assign count_m1    = count_reg - ONE_CNT;
    assign pos_bad     = (32'(req.position) >= 32'(count_reg));

    // Cell addressing: push at the tail, wrap at the last held element
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign wrap_idx = count_m1[IDX_W-1:0];
    assign rd_idx   = (req.kind == OP_GET) ? IDX_W'(req.position) : count_m1[IDX_W-1:0];
    assign wr_data  = '{second: req.element_second, first: req.element_first};

    // Search compare against the element at the head of the chain
    assign hit = (head.first == key_reg.first)
              && (!kind_cfg_reg || (head.second == key_reg.second));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.kind == OP_CONTAINS) && !list_vacant)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (walk_reg == ONE_CNT)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control and response
    always_comb
    begin
        ctl        = '0;
        count_next = count_reg;
        walk_next  = walk_reg;
        found_next = found_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        status     = ST_OK;
        value      = '0;
        found_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (req.kind)
                        OP_PUSH:
                        begin
                            if (is_full)
                                status = ST_FULL;
                            else
                            begin
                                ctl.push   = 1'b1;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        OP_POP_FRONT, OP_PEEK_FRONT:
                        begin
                            if (list_vacant)
                                status = ST_EMPTY;
                            else
                            begin
                                value = head;
                                if (req.kind == OP_POP_FRONT)
                                begin
                                    ctl.shift  = 1'b1;
                                    count_next = count_m1;
                                end
                            end
                        end
                        OP_POP_BACK, OP_PEEK_BACK:
                        begin
                            if (list_vacant)
                                status = ST_EMPTY;
                            else
                            begin
                                value = rd_data;
                                if (req.kind == OP_POP_BACK)
                                    count_next = count_m1;
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_bad)
                                status = ST_RANGE;
                            else
                                value = rd_data;
                        end
                        OP_CONTAINS:
                        begin
                            // empty list answers at once; otherwise walk
                            if (!list_vacant)
                            begin
                                done_next  = 1'b0;
                                walk_next  = count_reg;
                                found_next = 1'b0;
                                key_next   = wr_data;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default: status = ST_OK;
                    endcase
                end
            end
            S_SEARCH:
            begin
                // rotate the held elements once around the chain
                ctl.shift  = 1'b1;
                ctl.wrap   = 1'b1;
                walk_next  = walk_reg - ONE_CNT;
                found_next = found_reg | hit;
                if (walk_reg == ONE_CNT)
                begin
                    done_next = 1'b1;
                    found_out = found_reg | hit;
                end
            end
            default: done_next = 1'b0;
        endcase

        rsp_next.status        = status;
        rsp_next.value_first   = value.first;
        rsp_next.value_second  = value.second;
        rsp_next.found         = found_out;
        rsp_next.count         = 9'(count_next);
        rsp_next.is_full_flag  = (count_next == CAP_CNT);
        rsp_next.is_empty_flag = (count_next == '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            kind_cfg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
                kind_cfg_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        walk_reg  <= walk_next;
        found_reg <= found_next;
        key_reg   <= key_next;
        rsp_reg   <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/bounded_queue_stack_list_unit.sv =====
// Top level of the bounded queue/stack/list unit: a chain of element cells
// with the front at cell 0, driven by the sequencer.
// Depends on bqsl_pkg, bqsl_cell, bqsl_ctrl.
//
//  port          dir  transaction
//  ------------  ---  ----------------------------------------------------
//  start/busy    in   request req taken when start is high and busy is low
//  done          out  response rsp valid for exactly one cycle
//  cfg_wr_en     in   element kind register written from cfg_wr_data
//
// Every request but a search of a non-empty list answers in the cycle after
// it is taken, and the next request may follow at once. A search rotates the
// held elements once around the cell chain, one element per cycle, so busy
// stays high until the last step and the response follows it. Reset empties
// the list and clears the element kind. The receiver cannot stall responses.
module bounded_queue_stack_list_unit #(
    parameter int CAPACITY = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bqsl_pkg::req_t  req,
    output logic            done,
    output bqsl_pkg::rsp_t  rsp,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);
    import bqsl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t        ctl;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] wrap_idx;
    logic [IDX_W-1:0] rd_idx;
    elem_t            wr_data;
    elem_t            rd_data;
    elem_t            cell_q [CAPACITY];

    // Sequencer
    bqsl_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (cell_q[0]),
        .rd_data     (rd_data),
        .ctl         (ctl),
        .wr_idx      (wr_idx),
        .wrap_idx    (wrap_idx),
        .rd_idx      (rd_idx),
        .wr_data     (wr_data),
        .done        (done),
        .rsp         (rsp)
    );

    // Cell chain; the last cell feeds itself on a shift
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        elem_t right;
        if (i == CAPACITY - 1)
        begin : g_last
            assign right = cell_q[i];
        end
        else
        begin : g_mid
            assign right = cell_q[i + 1];
        end

        bqsl_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .wr_idx   (wr_idx),
            .wrap_idx (wrap_idx),
            .wr_data  (wr_data),
            .right    (right),
            .head     (cell_q[0]),
            .q        (cell_q[i])
        );
    end

    // Read select for the back element or a position from the front
    assign rd_data = cell_q[rd_idx];

endmodule
